### design/bpf_pkg.sv
// Package for the bootloader packet framer: job record passed from the
// front to the back, step codes, constants and the byte-wide CRC-32 update.
// No dependencies.
package bpf_pkg;

    localparam logic [7:0]  HEADER_RESET = 8'h80;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam int          QUEUE_DEPTH  = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // byte positions within a packet slice handled by the back end
    localparam logic [2:0] STEP_HEADER   = 3'd0;
    localparam logic [2:0] STEP_LEN_HI   = 3'd1;
    localparam logic [2:0] STEP_LEN_LO   = 3'd2;
    localparam logic [2:0] STEP_BYTE     = 3'd3;
    localparam logic [2:0] STEP_CRC_3    = 3'd4;
    localparam logic [2:0] STEP_CRC_2    = 3'd5;
    localparam logic [2:0] STEP_CRC_1    = 3'd6;
    localparam logic [2:0] STEP_CRC_0    = 3'd7;

    typedef enum logic [1:0] {
        K_START,
        K_DATA,
        K_ERROR
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic         close;   // CRC trailer follows
        logic [15:0]  total;
        logic [7:0]   data;
        logic [31:0]  crc;
    } t_job;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/bpf_ifs.sv
// Valid/ready channel interfaces of the packet framer: input items,
// output bytes and the header register write port. No dependencies.
interface bpf_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    modport source (output valid, op, command, payload_length, payload_byte,
                    input ready);
    modport sink   (input valid, op, command, payload_length, payload_byte,
                    output ready);
endinterface

interface bpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       packet_end;
    logic       error;
    modport source (output valid, out_byte, last, packet_end, error, input ready);
    modport sink   (input valid, out_byte, last, packet_end, error, output ready);
endinterface

interface bpf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    modport source (output valid, header_byte, input ready);
    modport sink   (input valid, header_byte, output ready);
endinterface

### design/bpf_front.sv
// Front end: accepts input beats, tracks packet state and running CRC,
// and turns each beat into a job for the back end. Uses bpf_pkg.
module bpf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpf_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output bpf_pkg::t_job o_job
);
    import bpf_pkg::*;

    logic [31:0] r_crc,  n_crc;
    logic [15:0] r_rem,  n_rem;
    logic        r_open, n_open;
    logic        accept;
    logic [15:0] rem_dec;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept;
    assign rem_dec    = r_rem - 16'd1;

    always_comb begin
        n_crc  = r_crc;
        n_rem  = r_rem;
        n_open = r_open;
        o_job.kind  = K_ERROR;
        o_job.close = 1'b0;
        o_job.total = i_in.payload_length + 16'd1;
        o_job.data  = i_in.payload_byte;
        o_job.crc   = r_crc;
        if (i_in.op == OP_START) begin
            n_crc  = crc_byte(CRC_INIT, i_in.command);
            n_rem  = i_in.payload_length;
            n_open = (i_in.payload_length != 16'd0);
            o_job.kind  = K_START;
            o_job.close = (i_in.payload_length == 16'd0);
            o_job.data  = i_in.command;
            o_job.crc   = n_crc;
        end else if (r_open) begin
            n_crc  = crc_byte(r_crc, i_in.payload_byte);
            n_rem  = rem_dec;
            n_open = (rem_dec != 16'd0);
            o_job.kind  = K_DATA;
            o_job.close = (rem_dec == 16'd0);
            o_job.crc   = n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_rem  <= 16'd0;
            r_open <= 1'b0;
        end else if (accept) begin
            r_crc  <= n_crc;
            r_rem  <= n_rem;
            r_open <= n_open;
        end
    end

endmodule

### design/bpf_queue.sv
// Short job queue between front and back ends, DEPTH entries, with
// first-word fall-through head. Uses bpf_pkg for the job record.
module bpf_queue #(
    parameter int DEPTH = bpf_pkg::QUEUE_DEPTH  // 2..8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output bpf_pkg::t_job o_job
);
    import bpf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### design/bpf_back.sv
// Back end: walks the head job byte by byte into the output register.
// Uses bpf_pkg for the job record and step codes.
module bpf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_header,
    input  logic          i_job_valid,
    input  bpf_pkg::t_job i_job,
    output logic          o_pop,
    bpf_out_if.source     o_out
);
    import bpf_pkg::*;

    logic [2:0] r_step;
    logic [2:0] base, idx, idx_end;
    logic       load, at_end;
    logic [7:0] sel_byte;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last, r_pend, r_err;

    // start and data jobs share the tail: data byte then CRC
    assign base    = (i_job.kind == K_START) ? STEP_HEADER : STEP_BYTE;
    assign idx     = base + r_step;
    assign idx_end = i_job.close ? STEP_CRC_0 : STEP_BYTE;
    assign at_end  = (idx == idx_end);
    assign load    = i_job_valid && (!r_valid || o_out.ready);
    assign o_pop   = load && at_end;

    always_comb begin
        unique case (idx)
            STEP_HEADER: sel_byte = i_header;
            STEP_LEN_HI: sel_byte = i_job.total[15:8];
            STEP_LEN_LO: sel_byte = i_job.total[7:0];
            STEP_BYTE:   sel_byte = (i_job.kind == K_ERROR) ? 8'd0 : i_job.data;
            STEP_CRC_3:  sel_byte = i_job.crc[31:24];
            STEP_CRC_2:  sel_byte = i_job.crc[23:16];
            STEP_CRC_1:  sel_byte = i_job.crc[15:8];
            STEP_CRC_0:  sel_byte = i_job.crc[7:0];
            default:     sel_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= at_end ? 3'd0 : r_step + 3'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= at_end;
            r_pend <= at_end && i_job.close;
            r_err  <= (i_job.kind == K_ERROR);
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.last       = r_last;
    assign o_out.packet_end = r_pend;
    assign o_out.error      = r_err;

endmodule

### design/bootloader_packet_framer_crc32_core.sv
// Bootloader packet framer with CRC-32/JAMCRC trailer, top level.
// An accepted beat is queued as a job; its bytes leave via the output register.
// Throughput: one byte per cycle from the back-end sequencer unless stalled;
// a data beat gives 1 byte (5 if it closes the packet), a start beat 4 (8 if empty).
// Reset: synchronous active-low i_rst_n clears packet state, queue and output;
// header register returns to 0x80. Depends on bpf_pkg, bpf_ifs and submodules.
module bootloader_packet_framer_crc32_core #(
    parameter int QDEPTH = bpf_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpf_in_if.sink     i_in,
    bpf_cfg_if.sink    i_cfg,
    bpf_out_if.source  o_out
);
    import bpf_pkg::*;

    logic [7:0] r_header;
    logic       q_full, q_valid, push, pop;
    t_job       push_job, head_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
        end else if (i_cfg.valid) begin
            r_header <= i_cfg.header_byte;
        end
    end

    bpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    bpf_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    bpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_header    (r_header),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

### design/bpf_checker.sv
// Port-level checks for the packet framer and the bind that attaches them.
// Depends on bootloader_packet_framer_crc32_core.
module bpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_byte,
    input logic       i_last,
    input logic       i_pend,
    input logic       i_err
);

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid straight after reset");

    a_pend_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_pend) |-> (i_last && !i_err))
        else $error("packet end beat not marked last");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_err) |-> (i_last && (i_byte == 8'd0)))
        else $error("malformed error beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_byte) && $stable(i_last)))
        else $error("stalled output beat changed");

endmodule

bind bootloader_packet_framer_crc32_core bpf_checker u_bpf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_byte  (o_out.out_byte),
    .i_last  (o_out.last),
    .i_pend  (o_out.packet_end),
    .i_err   (o_out.error)
);

### verif/bootloader_packet_framer_crc32_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the bootloader packet framer: predicts every framed
// beat from the accepted input beats and checks the output stream in order.
// Depends on bpf_pkg, bpf_ifs and the framer RTL.
module bootloader_packet_framer_crc32_core_test;

    localparam int QUIET_LIMIT  = 2000;
    localparam int END_SETTLE   = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 110;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pkt_end;
        logic       err;
    } t_frame_byte;

    class framer_scoreboard;
        t_frame_byte expected_bytes[$];
        logic [7:0]  header;
        logic [31:0] crc;
        logic [15:0] remaining;
        bit          pkt_open;
        int          mismatches;

        function new();
            header     = bpf_pkg::HEADER_RESET;
            crc        = bpf_pkg::CRC_INIT;
            remaining  = '0;
            pkt_open   = 1'b0;
            mismatches = 0;
        endfunction

        function void set_header(input logic [7:0] value);
            header = value;
        endfunction

        // reflected CRC-32, one byte, lsb first
        function logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
            logic [31:0] mask;
            c = c ^ {24'd0, b};
            for (int i = 0; i < 8; i++) begin
                mask = {32{c[0]}};
                c = (c >> 1) ^ (bpf_pkg::CRC_POLY & mask);
            end
            return c;
        endfunction

        function void push_byte(input logic [7:0] d, input logic lst, input logic pend,
                                input logic err);
            t_frame_byte b;
            b.data    = d;
            b.last    = lst;
            b.pkt_end = pend;
            b.err     = err;
            expected_bytes.push_back(b);
        endfunction

        // CRC trailer, most significant byte first; closes the packet
        function void push_trailer();
            for (int i = 3; i >= 0; i--) begin
                push_byte(crc[8*i +: 8], i == 0, i == 0, 1'b0);
            end
            pkt_open = 1'b0;
        endfunction

        function void take_item(input logic op, input logic [7:0] cmd,
                                input logic [15:0] plen, input logic [7:0] pbyte);
            logic [15:0] total;
            if (op == bpf_pkg::OP_START) begin
                total     = plen + 16'd1;
                crc       = crc_update(bpf_pkg::CRC_INIT, cmd);
                remaining = plen;
                pkt_open  = 1'b1;
                push_byte(header, 1'b0, 1'b0, 1'b0);
                push_byte(total[15:8], 1'b0, 1'b0, 1'b0);
                push_byte(total[7:0], 1'b0, 1'b0, 1'b0);
                push_byte(cmd, plen != 16'd0, 1'b0, 1'b0);
                if (plen == 16'd0)
                    push_trailer();
            end else if (!pkt_open) begin
                push_byte(8'h00, 1'b1, 1'b0, 1'b1);
            end else begin
                crc       = crc_update(crc, pbyte);
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) begin
                    push_byte(pbyte, 1'b0, 1'b0, 1'b0);
                    push_trailer();
                end else begin
                    push_byte(pbyte, 1'b1, 1'b0, 1'b0);
                end
            end
        endfunction

        function void check_byte(input t_frame_byte got);
            t_frame_byte want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: byte %02h last %0b end %0b err %0b",
                             got.data, got.last, got.pkt_end, got.err);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.data !== want.data || got.last !== want.last ||
                got.pkt_end !== want.pkt_end || got.err !== want.err) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: expected byte %02h last %0b end %0b err %0b,",
                              " got byte %02h last %0b end %0b err %0b"},
                             want.data, want.last, want.pkt_end, want.err,
                             got.data, got.last, got.pkt_end, got.err);
            end
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction

        function bit clean();
            return mismatches == 0 && expected_bytes.size() == 0;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;

    framer_scoreboard board;
    t_frame_byte      seen;

    bpf_in_if  in_ch();
    bpf_cfg_if cfg_ch();
    bpf_out_if out_ch();

    bootloader_packet_framer_crc32_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // valid stays high between back-to-back beats; lowered only for a gap
    task automatic send_item(input logic op, input logic [7:0] cmd,
                             input logic [15:0] plen, input logic [7:0] pbyte);
        if (coin(send_idle_pct)) begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while (coin(send_idle_pct));
        end
        in_ch.valid          <= 1'b1;
        in_ch.op             <= op;
        in_ch.command        <= cmd;
        in_ch.payload_length <= plen;
        in_ch.payload_byte   <= pbyte;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        board.take_item(op, cmd, plen, pbyte);
    endtask

    task automatic send_packet(input logic [7:0] cmd, input int len, input int n_data);
        send_item(bpf_pkg::OP_START, cmd, len[15:0], 8'($urandom));
        repeat (n_data) send_item(bpf_pkg::OP_DATA, 8'($urandom), 16'($urandom),
                                  8'($urandom));
    endtask

    // hold the sender off until every predicted beat has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (board.outstanding() != 0);
    endtask

    task automatic write_header(input logic [7:0] value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.header_byte <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        board.set_header(value);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic directed_items();
        send_item(bpf_pkg::OP_DATA, 8'hFF, 16'hFFFF, 8'hFF);   // nothing open yet
        send_item(bpf_pkg::OP_START, 8'h00, 16'd0, 8'hFF);     // empty payload
        send_item(bpf_pkg::OP_START, 8'hFF, 16'd2, 8'h00);
        send_item(bpf_pkg::OP_DATA, 8'h00, 16'h0000, 8'h00);
        send_item(bpf_pkg::OP_DATA, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(bpf_pkg::OP_START, 8'h3C, 16'hFFFF, 8'h00);  // length field wraps to 0
        send_item(bpf_pkg::OP_DATA, 8'h00, 16'h0000, 8'hAA);
        send_item(bpf_pkg::OP_START, 8'h12, 16'hFFFE, 8'h5A);  // abandons the open packet
        send_item(bpf_pkg::OP_DATA, 8'hC3, 16'h1234, 8'h55);
        send_item(bpf_pkg::OP_START, 8'hC3, 16'd1, 8'h00);     // abandons again
        send_item(bpf_pkg::OP_DATA, 8'h00, 16'h0000, 8'h81);
        send_item(bpf_pkg::OP_DATA, 8'h99, 16'h8001, 8'h7E);   // closed: error beat
        send_packet(8'hA5, 3, 3);
    endtask

    task automatic random_traffic(input int n_items);
        int sent;
        int len;
        int cut;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = coin(10) ? $urandom_range(64, 7) : $urandom_range(6);
                send_packet(8'($urandom), len, len);
                sent += len + 1;
            end else if (pick < 82) begin
                // left open for a later start to abandon, unless the length is zero
                len = $urandom_range(65535);
                cut = $urandom_range(5);
                if (cut >= len)
                    cut = 0;
                send_packet(8'($urandom), len, cut);
                sent += cut + 1;
            end else if (pick < 98) begin
                send_item(bpf_pkg::OP_DATA, 8'($urandom), 16'($urandom), 8'($urandom));
                sent++;
            end else begin
                drain();
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            seen.data    = out_ch.out_byte;
            seen.last    = out_ch.last;
            seen.pkt_end = out_ch.packet_end;
            seen.err     = out_ch.error;
            board.check_byte(seen);
        end
        out_ch.ready <= !coin(recv_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        board                = new();
        rst_n                = 1'b0;
        quiet_cycles         = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        in_ch.valid          = 1'b0;
        in_ch.op             = bpf_pkg::OP_START;
        in_ch.command        = '0;
        in_ch.payload_length = '0;
        in_ch.payload_byte   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.header_byte   = '0;
        out_ch.ready         = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // header left at its reset value for the directed beats
        directed_items();
        drain();

        write_header(8'hFF);
        random_traffic(PHASE_ITEMS);
        drain();

        write_header(8'h00);
        send_idle_pct = 81;
        random_traffic(PHASE_ITEMS);
        drain();

        write_header(8'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        random_traffic(PHASE_ITEMS);
        drain();

        write_header(8'($urandom));
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        random_traffic(PHASE_ITEMS);
        drain();

        repeat (END_SETTLE) @(posedge clk);
        if (board.clean())
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
